// ----- rtl/esa_pkg.sv -----
`timescale 1ns / 1ps
package esa_pkg;

   localparam int VALUE_W = 32;
   localparam int INDEX_W = 8;
   localparam int RCOL_W  = 5;
   localparam int COL_W   = 6;
   localparam int ROWS_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic ACT_ACCUM = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_DROP = 2'd1;
   localparam logic [1:0] STATUS_SAT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MULTI_IDX  = 2'd2;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fffffff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh80000000;

   typedef struct packed {
      logic [ROWS_W-1:0] table_rows;
      logic [COL_W-1:0]  row_width;
      logic              multi_index;
   } esa_cfg_type;

   typedef struct packed {
      logic                      action;
      logic                      ok;
      logic signed [VALUE_W-1:0] grad;
   } esa_op_type;

endpackage

// ----- rtl/esa_ram.sv -----
`timescale 1ns / 1ps
module esa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8192,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/esa_front.sv -----
`timescale 1ns / 1ps
module esa_front #(
   parameter int MAX_ROWS  = 256,
   parameter int MAX_WIDTH = 32,
   parameter int AW        = 13
) (
   input  logic                                clock,
   input  logic                                reset,
   input  esa_pkg::esa_cfg_type                cfg,
   input  logic                                accept,
   input  logic                                action,
   input  logic signed [esa_pkg::VALUE_W-1:0]  grad_value,
   input  logic [esa_pkg::INDEX_W-1:0]         embedding_index,
   input  logic [esa_pkg::RCOL_W-1:0]          read_column,
   output esa_pkg::esa_op_type                 op,
   output logic [AW-1:0]                       addr
);

   logic [esa_pkg::COL_W-1:0]   col_ff, col_in;
   logic [esa_pkg::INDEX_W-1:0] latch_ff, latch_in;
   logic [esa_pkg::COL_W-1:0]   width_eff;
   logic [esa_pkg::COL_W-1:0]   col_cur, col_inc, col_sel;
   logic [esa_pkg::INDEX_W-1:0] row_sel;
   logic                        row_ok, col_ok;
   logic [31:0]                 addr_full;

   function automatic logic col_fits(input logic [esa_pkg::COL_W-1:0] c,
                                     input logic [esa_pkg::COL_W-1:0] w);
      return (c < w) && (32'(c) < MAX_WIDTH);
   endfunction

   always_comb begin
      width_eff = (cfg.row_width == '0) ? esa_pkg::COL_W'(1) : cfg.row_width;
      // restart a stale counter left over from a width change
      col_cur = col_fits(col_ff, width_eff) ? col_ff : '0;
      col_inc = col_cur + esa_pkg::COL_W'(1);
      col_in  = col_ff;
      latch_in = latch_ff;

      if (action == esa_pkg::ACT_READ) begin
         row_sel = embedding_index;
         col_sel = esa_pkg::COL_W'(read_column);
      end else begin
         col_sel = col_cur;
         if (cfg.multi_index || col_cur != '0) begin
            row_sel = cfg.multi_index ? embedding_index : latch_ff;
         end else begin
            row_sel = embedding_index;
         end
         if (!cfg.multi_index && col_cur == '0) begin
            latch_in = embedding_index;
         end
         col_in = col_fits(col_inc, width_eff) ? col_inc : '0;
      end

      row_ok = (esa_pkg::ROWS_W'(row_sel) < cfg.table_rows) && (32'(row_sel) < MAX_ROWS);
      col_ok = col_fits(col_sel, width_eff);
      addr_full = 32'(row_sel) * 32'(MAX_WIDTH) + 32'(col_sel);
      addr = addr_full[AW-1:0];

      op.action = action;
      op.ok     = row_ok && col_ok;
      op.grad   = grad_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         latch_ff <= '0;
      end else if (accept) begin
         col_ff   <= col_in;
         latch_ff <= latch_in;
      end
   end

endmodule

// ----- rtl/esa_update.sv -----
`timescale 1ns / 1ps
module esa_update #(
   parameter int AW = 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  esa_pkg::esa_op_type                op,
   input  logic [AW-1:0]                      addr,
   input  logic [esa_pkg::VALUE_W-1:0]        ram_q,
   output logic                               wr_en,
   output logic [AW-1:0]                      wr_addr,
   output logic [esa_pkg::VALUE_W-1:0]        wr_data,
   output logic                               busy,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [esa_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [1:0]                         rsp_status
);

   logic                               s1_valid_ff;
   esa_pkg::esa_op_type                s1_op_ff;
   logic [AW-1:0]                      s1_addr_ff;
   logic                               fwd_valid_ff;
   logic [AW-1:0]                      fwd_addr_ff;
   logic [esa_pkg::VALUE_W-1:0]        fwd_data_ff;
   logic                               rsp_valid_ff;
   logic signed [esa_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [1:0]                         status_ff, status_in;
   logic                               out_free;
   logic signed [esa_pkg::VALUE_W-1:0] cur;
   logic signed [esa_pkg::VALUE_W:0]   sum;
   logic [esa_pkg::VALUE_W-1:0]        new_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign busy     = s1_valid_ff && !out_free;

   always_comb begin
      // the write in the cycle of this entry's read is not yet in the RAM data
      cur = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : ram_q;
      sum = {cur[esa_pkg::VALUE_W-1], cur} +
            {s1_op_ff.grad[esa_pkg::VALUE_W-1], s1_op_ff.grad};
      value_in  = '0;
      status_in = esa_pkg::STATUS_OK;
      new_val   = '0;
      if (!s1_op_ff.ok) begin
         status_in = esa_pkg::STATUS_DROP;
      end else if (s1_op_ff.action == esa_pkg::ACT_READ) begin
         value_in = cur;
      end else if (sum[esa_pkg::VALUE_W] != sum[esa_pkg::VALUE_W-1]) begin
         new_val   = sum[esa_pkg::VALUE_W] ? esa_pkg::VALUE_MIN : esa_pkg::VALUE_MAX;
         status_in = esa_pkg::STATUS_SAT;
      end else begin
         new_val = sum[esa_pkg::VALUE_W-1:0];
      end
   end

   assign wr_en   = s1_valid_ff && out_free && s1_op_ff.ok;
   assign wr_addr = s1_addr_ff;
   assign wr_data = new_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (out_free) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (wr_en) begin
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= op;
         s1_addr_ff <= addr;
      end
      if (wr_en) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= new_val;
      end
      if (out_free && s1_valid_ff) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = value_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- rtl/embedding_gradient_scatter_add.sv -----
`timescale 1ns / 1ps
// Scatter-adds a stream of signed Q16.16 gradient elements into a table of
// MAX_ROWS x MAX_WIDTH entries held in one single-port-write, registered-read
// RAM, and reads back and clears single entries. Each transaction is a
// read-modify-write of one entry: the RAM read is issued when the request is
// taken, the sum and write-back happen from the s1 registers, and the result
// is registered again before it appears. A new request is taken each cycle
// unless a stalled response holds s1; a write to the entry that the next
// request reads is forwarded, so repeated indices need no bubble. After reset
// the table is cleared one entry per cycle; req_stall stays high until done,
// while CSR writes are taken. Change the CSRs only while the block is idle.
module embedding_gradient_scatter_add #(
   parameter int MAX_ROWS  = 256,
   parameter int MAX_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [esa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [esa_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [esa_pkg::VALUE_W-1:0]  req_grad_value,
   input  logic [esa_pkg::INDEX_W-1:0]         req_embedding_index,
   input  logic [esa_pkg::RCOL_W-1:0]          req_read_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [esa_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [1:0]                          rsp_status
);

   localparam int DEPTH = MAX_ROWS * MAX_WIDTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   esa_pkg::esa_cfg_type        cfg_ff;
   logic                        clear_ff;
   logic [AW-1:0]               clr_cnt_ff;
   logic                        accept, busy;
   esa_pkg::esa_op_type         op;
   logic [AW-1:0]               op_addr;
   logic                        upd_wr_en;
   logic [AW-1:0]               upd_wr_addr;
   logic [esa_pkg::VALUE_W-1:0] upd_wr_data;
   logic                        ram_wr_en;
   logic [AW-1:0]               ram_wr_addr;
   logic [esa_pkg::VALUE_W-1:0] ram_wr_data, ram_q;

   assign req_stall = clear_ff || busy;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_rows  <= esa_pkg::ROWS_W'(256);
         cfg_ff.row_width   <= esa_pkg::COL_W'(32);
         cfg_ff.multi_index <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            esa_pkg::CSR_TABLE_ROWS: cfg_ff.table_rows  <= csr_wr_data;
            esa_pkg::CSR_ROW_WIDTH:  cfg_ff.row_width   <= csr_wr_data[esa_pkg::COL_W-1:0];
            esa_pkg::CSR_MULTI_IDX:  cfg_ff.multi_index <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // sweep zeros through the table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
      end else if (clear_ff) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (clr_cnt_ff == AW'(DEPTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   assign ram_wr_en   = clear_ff || upd_wr_en;
   assign ram_wr_addr = clear_ff ? clr_cnt_ff : upd_wr_addr;
   assign ram_wr_data = clear_ff ? '0 : upd_wr_data;

   esa_front #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .accept          (accept),
      .action          (req_action),
      .grad_value      (req_grad_value),
      .embedding_index (req_embedding_index),
      .read_column     (req_read_column),
      .op              (op),
      .addr            (op_addr)
   );

   esa_ram #(
      .WIDTH (esa_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (op_addr),
      .rd_data (ram_q)
   );

   esa_update #(
      .AW (AW)
   ) u_update (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .op             (op),
      .addr           (op_addr),
      .ram_q          (ram_q),
      .wr_en          (upd_wr_en),
      .wr_addr        (upd_wr_addr),
      .wr_data        (upd_wr_data),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status)
   );

endmodule

// ----- test/tb_embedding_gradient_scatter_add.sv -----
`timescale 1ns / 1ps
module tb_embedding_gradient_scatter_add;

   localparam int MAX_ROWS    = 256;
   localparam int MAX_WIDTH   = 32;
   localparam int CYCLE_LIMIT = 300000;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 8;
   localparam logic [esa_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic                               action;
      logic signed [esa_pkg::VALUE_W-1:0] grad;
      logic [esa_pkg::INDEX_W-1:0]        index;
      logic [esa_pkg::RCOL_W-1:0]         rcol;
   } grad_req_type;

   typedef struct packed {
      logic signed [esa_pkg::VALUE_W-1:0] value;
      logic [1:0]                         status;
   } readout_type;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_wr_en = 1'b0;
   logic [esa_pkg::CSR_IDX_W-1:0]      csr_index = '0;
   logic [esa_pkg::CSR_DATA_W-1:0]     csr_wr_data = '0;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_action = esa_pkg::ACT_ACCUM;
   logic signed [esa_pkg::VALUE_W-1:0] req_grad_value = '0;
   logic [esa_pkg::INDEX_W-1:0]        req_embedding_index = '0;
   logic [esa_pkg::RCOL_W-1:0]         req_read_column = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic signed [esa_pkg::VALUE_W-1:0] rsp_read_value;
   logic [1:0]                         rsp_status;

   // shadow of the block: gradient sums, column walker, row latch, registers
   logic signed [esa_pkg::VALUE_W-1:0] grad_sums [MAX_ROWS*MAX_WIDTH];
   int                                 col_pos = 0;
   logic [esa_pkg::INDEX_W-1:0]        row_latch = '0;
   logic [esa_pkg::ROWS_W-1:0]         cfg_rows = 9'd256;
   logic [esa_pkg::COL_W-1:0]          cfg_width = 6'd32;
   logic                               cfg_multi = 1'b0;

   grad_req_type grad_items[$];
   readout_type  pending_readouts[$];

   logic req_fire = 1'b0;
   logic calm = 1'b0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   hold_ask = 0;
   int   hold_done = 0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   accepted_count = 0;
   int   read_total = 0;
   int   drop_total = 0;
   int   sat_total = 0;
   int   setting_count = 0;

   embedding_gradient_scatter_add #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_grad_value      (req_grad_value),
      .req_embedding_index (req_embedding_index),
      .req_read_column     (req_read_column),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_value      (rsp_read_value),
      .rsp_status          (rsp_status)
   );

   always #10 clock = ~clock;

   function automatic int rows_now();
      return (cfg_rows < MAX_ROWS) ? int'(cfg_rows) : MAX_ROWS;
   endfunction

   function automatic int width_now();
      int w;
      w = (cfg_width == 0) ? 1 : int'(cfg_width);
      return (w < MAX_WIDTH) ? w : MAX_WIDTH;
   endfunction

   function automatic void predict_scatter_add(input grad_req_type req,
                                               output readout_type res);
      int     rows;
      int     width;
      int     col;
      int     row;
      int     addr;
      longint sum;
      rows = rows_now();
      width = width_now();
      res.value = '0;
      res.status = esa_pkg::STATUS_OK;
      if (req.action == esa_pkg::ACT_READ) begin
         read_total++;
         if (req.index < rows && req.rcol < width) begin
            addr = req.index * MAX_WIDTH + req.rcol;
            res.value = grad_sums[addr];
            grad_sums[addr] = '0;
         end else begin
            res.status = esa_pkg::STATUS_DROP;
         end
      end else begin
         col = (col_pos >= width) ? 0 : col_pos;
         if (cfg_multi) begin
            row = int'(req.index);
         end else begin
            if (col == 0) row_latch = req.index;
            row = int'(row_latch);
         end
         if (row < rows) begin
            addr = row * MAX_WIDTH + col;
            sum = longint'(grad_sums[addr]) + longint'(req.grad);
            if (sum > longint'(esa_pkg::VALUE_MAX)) begin
               sum = longint'(esa_pkg::VALUE_MAX);
               res.status = esa_pkg::STATUS_SAT;
            end else if (sum < longint'(esa_pkg::VALUE_MIN)) begin
               sum = longint'(esa_pkg::VALUE_MIN);
               res.status = esa_pkg::STATUS_SAT;
            end
            grad_sums[addr] = sum[esa_pkg::VALUE_W-1:0];
         end else begin
            res.status = esa_pkg::STATUS_DROP;
         end
         col_pos = (col + 1 >= width) ? 0 : col + 1;
      end
      if (res.status == esa_pkg::STATUS_DROP) drop_total++;
      if (res.status == esa_pkg::STATUS_SAT) sat_total++;
   endfunction

   // accept, predict, and check in one place so ordering within a step is fixed
   always @(posedge clock) begin : monitor_rsp
      grad_req_type taken;
      readout_type  want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("embedding_gradient_scatter_add verification failed");
         $finish;
      end else if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            taken.action = req_action;
            taken.grad = req_grad_value;
            taken.index = req_embedding_index;
            taken.rcol = req_read_column;
            predict_scatter_add(taken, want);
            pending_readouts.push_back(want);
            accepted_count++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_readouts.size() == 0) begin
               $error("rsp transaction with no request outstanding");
               mismatch_count++;
            end else begin
               want = pending_readouts.pop_front();
               if (rsp_read_value !== want.value) begin
                  $error("read_value: expected %0h, got %0h", want.value, rsp_read_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(negedge clock) begin : drive_req
      grad_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (grad_items.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else begin
            nxt = grad_items.pop_front();
            req_valid <= 1'b1;
            req_action <= nxt.action;
            req_grad_value <= nxt.grad;
            req_embedding_index <= nxt.index;
            req_read_column <= nxt.rcol;
         end
      end
   end

   // long hold-off is counted here so the sender keeps offering meanwhile
   always @(negedge clock) begin : drive_rsp_stall
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_done != hold_ask) begin
         hold_done = hold_ask;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_csr(input logic [esa_pkg::CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value[esa_pkg::CSR_DATA_W-1:0];
      case (idx)
         esa_pkg::CSR_TABLE_ROWS: cfg_rows = value[esa_pkg::ROWS_W-1:0];
         esa_pkg::CSR_ROW_WIDTH:  cfg_width = value[esa_pkg::COL_W-1:0];
         esa_pkg::CSR_MULTI_IDX:  cfg_multi = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_geometry(input int rows, input int width, input logic multi);
      write_csr(esa_pkg::CSR_TABLE_ROWS, rows);
      write_csr(esa_pkg::CSR_ROW_WIDTH, width);
      write_csr(esa_pkg::CSR_MULTI_IDX, int'(multi));
      setting_count++;
   endtask

   task automatic push_item(input logic act, input logic signed [esa_pkg::VALUE_W-1:0] g,
                            input logic [esa_pkg::INDEX_W-1:0] idx,
                            input logic [esa_pkg::RCOL_W-1:0] rc);
      grad_req_type it;
      it.action = act;
      it.grad = g;
      it.index = idx;
      it.rcol = rc;
      grad_items.push_back(it);
   endtask

   function automatic logic signed [esa_pkg::VALUE_W-1:0] pick_grad();
      case ($urandom_range(0, 9))
         0: return esa_pkg::VALUE_MAX;
         1: return esa_pkg::VALUE_MIN;
         2: return $urandom_range(0, 'h3ffff) - 'h20000;
         default: return $urandom;
      endcase
   endfunction

   // bias toward a few hot rows so entries pile up and saturate
   function automatic logic [esa_pkg::INDEX_W-1:0] pick_index();
      int lim;
      lim = rows_now();
      if (lim > 255) lim = 255;
      case ($urandom_range(0, 9))
         0, 1: return esa_pkg::INDEX_W'($urandom_range(0, 255));
         2, 3: return esa_pkg::INDEX_W'($urandom_range(0, 3));
         default: return esa_pkg::INDEX_W'($urandom_range(0, lim));
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 4) == 0)
               push_item(esa_pkg::ACT_READ, $urandom, pick_index(),
                         esa_pkg::RCOL_W'($urandom_range(0, 31)));
            else
               push_item(esa_pkg::ACT_READ, $urandom, pick_index(),
                         esa_pkg::RCOL_W'($urandom_range(0, width_now())));
         end else begin
            push_item(esa_pkg::ACT_ACCUM, pick_grad(), pick_index(),
                      esa_pkg::RCOL_W'($urandom));
         end
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (grad_items.size() != 0 || req_valid || pending_readouts.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      foreach (grad_sums[i]) grad_sums[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single index, few rows: saturation both ways, dropped row, reads clear
      set_geometry(4, 3, 1'b0);
      push_item(esa_pkg::ACT_ACCUM, esa_pkg::VALUE_MAX, 8'd1, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd1, 8'd9, 5'd31);
      push_item(esa_pkg::ACT_ACCUM, esa_pkg::VALUE_MIN, 8'd200, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd1, 8'd1, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, -32'sd1, 8'd0, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, -32'sd1, 8'd0, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd5, 8'd7, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd5, 8'd1, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd5, 8'd2, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd1, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd1, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd4, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd0, 5'd3);
      push_item(esa_pkg::ACT_ACCUM, 32'sh0001_0000, 8'd3, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sh0000_ffff, 8'd0, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd3, 5'd0);
      wait_idle();

      // narrower rows leave the column walker past the end: restart at zero
      set_geometry(300, 2, 1'b0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd7, 8'd5, 5'd0);
      push_item(esa_pkg::ACT_ACCUM, 32'sd8, 8'd255, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd5, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd5, 5'd1);
      push_item(esa_pkg::ACT_READ, '0, 8'd5, 5'd2);
      push_item(esa_pkg::ACT_READ, '0, 8'd255, 5'd31);
      wait_idle();

      // no rows in use; the spare register index must change nothing
      set_geometry(0, 0, 1'b1);
      write_csr(CSR_SPARE, 511);
      push_item(esa_pkg::ACT_ACCUM, 32'sd1, 8'd0, 5'd0);
      push_item(esa_pkg::ACT_READ, '0, 8'd0, 5'd0);
      wait_idle();

      set_geometry(256, 32, 1'b0);
      hold_ask++;
      queue_random(300);
      wait_idle();
      set_geometry(256, 32, 1'b1);
      queue_random(200);
      wait_idle();
      set_geometry(8, 4, 1'b0);
      queue_random(200);
      wait_idle();
      set_geometry(1, 1, 1'b1);
      queue_random(150);
      wait_idle();
      set_geometry(256, 40, 1'b1);
      queue_random(150);
      wait_idle();
      set_geometry(3, 5, 1'b0);
      queue_random(150);
      wait_idle();
      set_geometry(511, 7, 1'b1);
      queue_random(150);
      wait_idle();
      set_geometry(16, 0, 1'b0);
      queue_random(150);
      wait_idle();

      // back-to-back stretch with neither side idling
      calm = 1'b1;
      set_geometry(5, 3, 1'b1);
      queue_random(300);
      wait_idle();

      $display("Covered %0d transactions over %0d register settings, %0d of them reads;",
               accepted_count, setting_count, read_total);
      $display("%0d were dropped as out of range and %0d saturated.", drop_total, sat_total);
      if (mismatch_count == 0)
         $display("embedding_gradient_scatter_add verification clean");
      else
         $display("embedding_gradient_scatter_add verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/esa_pkg.sv
rtl/esa_ram.sv
rtl/esa_front.sv
rtl/esa_update.sv
rtl/embedding_gradient_scatter_add.sv
test/tb_embedding_gradient_scatter_add.sv
